/* src/marc_pkg.sv */
// ----------------------------------------------------------------------------
// Moving average and rate of change: shared package
// Sizes, widths, register indexes and the controller/datapath interface
// structures that the block's modules share.
// ----------------------------------------------------------------------------
package marc_pkg;

   // History depths.
   localparam int MAX_WINDOW = 64;
   localparam int MAX_LAG    = 127;
   localparam int OPEN_DEPTH = MAX_LAG + 1;
   localparam int SEEN_CAP   = (MAX_WINDOW > OPEN_DEPTH) ? MAX_WINDOW : OPEN_DEPTH;

   // Field widths.
   localparam int PRICE_W   = 32;
   localparam int RATE_W    = 24;
   localparam int FRAC_BITS = 16;
   localparam int CFG_W     = 7;

   // Derived widths.
   localparam int WIN_AW    = $clog2(MAX_WINDOW);
   localparam int OPEN_AW   = $clog2(OPEN_DEPTH);
   localparam int SEEN_W    = $clog2(SEEN_CAP + 1);
   localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
   localparam int LAG_W     = $clog2(MAX_LAG + 1);
   localparam int SUM_W     = PRICE_W + WIN_AW;
   localparam int DIVD_W    = PRICE_W + FRAC_BITS;
   localparam int DIVS_W    = PRICE_W;
   localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

   // Register reset values.
   localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(5);
   localparam logic [CFG_W-1:0] LAG_RESET    = CFG_W'(40);

   // Register indexes on the configuration channel.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MA_WINDOW = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_LAG  = 1'd1;

   // Saturation limits of the Q8.16 rate, as magnitudes.
   localparam logic [DIVD_W-1:0] RATE_POS_MAX = DIVD_W'((64'd1 << (RATE_W - 1)) - 64'd1);
   localparam logic [DIVD_W-1:0] RATE_NEG_MAG = DIVD_W'(64'd1 << (RATE_W - 1));

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic store;
      logic sum_run;
      logic div_ma_start;
      logic ma_take;
      logic div_rate_start;
      logic rate_take;
      logic load_out;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sum_done;
      logic div_done;
      logic ref_zero;
      logic out_free;
   } dp_status_type;

endpackage

/* src/marc_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module marc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/marc_divider.sv */
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module marc_divider import marc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic [DIVD_W-1:0] quotient,
   output logic              done
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVS_W-1:0]    rem_ff, rem_in;
   logic [DIVD_W-1:0]    quo_ff, quo_in;
   logic [DIVS_W-1:0]    dvs_ff, dvs_in;
   logic [DIVS_W:0]      trial;

   // The trial remainder brings down the next dividend bit.
   assign trial = {rem_ff, quo_ff[DIVD_W-1]};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVD_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in = DIVS_W'(trial - {1'b0, dvs_ff});
               quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DIVS_W-1:0];
               quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = busy_ff && (cnt_ff == '0);

endmodule

/* src/marc_datapath.sv */
// ----------------------------------------------------------------------------
// Moving average and rate of change: datapath
// Histories, window accumulation, shared divider and the result register.
// ----------------------------------------------------------------------------
module marc_datapath import marc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  dp_cmd_type                  cmd,
   output dp_status_type               status,
   input  logic                        req_series_start,
   input  logic [PRICE_W-1:0]          req_open_price,
   input  logic [PRICE_W-1:0]          req_close_price,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_data,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [PRICE_W-1:0]          rsp_moving_average,
   output logic signed [RATE_W-1:0]    rsp_change_rate,
   output logic                        rsp_rate_valid
);

   // Configuration registers.
   logic [CFG_W-1:0] cfg_window_ff, cfg_lag_ff;

   // Captured bar.
   logic               start_ff;
   logic [PRICE_W-1:0] open_ff, close_ff;

   // Series bookkeeping.
   logic [SEEN_W-1:0]  bars_ff, bars_in;
   logic [WIN_AW-1:0]  close_slot_ff, close_slot_in;
   logic [OPEN_AW-1:0] open_slot_ff, open_slot_in;

   // Window accumulation.
   logic [WIN_AW-1:0]  sum_addr_ff, sum_addr_in;
   logic [CNT_W-1:0]   sum_cnt_ff, sum_cnt_in;
   logic               pend_ff, pend_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]   n_ff;
   logic [OPEN_AW-1:0] ref_addr_ff;

   // Rate operands and results.
   logic [PRICE_W-1:0] ref_ff, mag_ff;
   logic               neg_ff;
   logic [PRICE_W-1:0] mean_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic               rate_valid_ff;

   // Result register.
   logic               out_valid_ff, out_valid_in;
   logic [PRICE_W-1:0] out_mean_ff;
   logic [RATE_W-1:0]  out_rate_ff;
   logic               out_rate_valid_ff;

   // Store-step values.
   logic [CNT_W-1:0]   w_eff, n_new;
   logic [LAG_W-1:0]   lag_eff, back;
   logic [SEEN_W-1:0]  bars_m1;
   logic [WIN_AW-1:0]  cslot;
   logic [OPEN_AW-1:0] oslot;
   logic [OPEN_AW:0]   ref_wide;

   // Memories and divider.
   logic [PRICE_W-1:0] close_rd, open_rd;
   logic               div_start, div_done;
   logic [DIVD_W-1:0]  div_dividend, div_quotient, rate_mag;
   logic [DIVS_W-1:0]  div_divisor;
   logic [RATE_W-1:0]  rate_sat;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_window_ff <= WINDOW_RESET;
         cfg_lag_ff    <= LAG_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MA_WINDOW: cfg_window_ff <= csr_data;
            CSR_RATE_LAG:  cfg_lag_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // ---- capture ----
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         start_ff <= req_series_start;
         open_ff  <= req_open_price;
         close_ff <= req_close_price;
      end
   end

   // ---- store step: new count, window length, lag and addresses ----
   always_comb begin
      if (cfg_window_ff == '0) begin
         w_eff = CNT_W'(1);
      end else if (int'(cfg_window_ff) > MAX_WINDOW) begin
         w_eff = CNT_W'(MAX_WINDOW);
      end else begin
         w_eff = CNT_W'(cfg_window_ff);
      end

      if (int'(cfg_lag_ff) > MAX_LAG) begin
         lag_eff = LAG_W'(MAX_LAG);
      end else begin
         lag_eff = LAG_W'(cfg_lag_ff);
      end

      // A new series restarts the count and both slots.
      if (start_ff) begin
         bars_in = SEEN_W'(1);
         cslot   = '0;
         oslot   = '0;
      end else begin
         bars_in = (int'(bars_ff) < SEEN_CAP) ? bars_ff + 1'b1 : bars_ff;
         cslot   = close_slot_ff;
         oslot   = open_slot_ff;
      end

      n_new   = (bars_in < SEEN_W'(w_eff)) ? CNT_W'(bars_in) : w_eff;
      bars_m1 = bars_in - 1'b1;
      back    = (SEEN_W'(lag_eff) < bars_m1) ? lag_eff : LAG_W'(bars_m1);

      if (oslot >= OPEN_AW'(back)) begin
         ref_wide = {1'b0, oslot} - (OPEN_AW + 1)'(back);
      end else begin
         ref_wide = {1'b0, oslot} + (OPEN_AW + 1)'(OPEN_DEPTH) - (OPEN_AW + 1)'(back);
      end

      close_slot_in = (int'(cslot) == MAX_WINDOW - 1) ? '0 : cslot + 1'b1;
      open_slot_in  = (int'(oslot) == OPEN_DEPTH - 1) ? '0 : oslot + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bars_ff       <= '0;
         close_slot_ff <= '0;
         open_slot_ff  <= '0;
      end else if (cmd.store) begin
         bars_ff       <= bars_in;
         close_slot_ff <= close_slot_in;
         open_slot_ff  <= open_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         n_ff        <= n_new;
         ref_addr_ff <= ref_wide[OPEN_AW-1:0];
      end
   end

   // ---- window accumulation: one close read per cycle, newest first ----
   always_comb begin
      sum_cnt_in  = sum_cnt_ff;
      sum_addr_in = sum_addr_ff;
      pend_in     = pend_ff;
      acc_in      = acc_ff;
      if (cmd.store) begin
         sum_cnt_in  = n_new;
         sum_addr_in = cslot;
         pend_in     = 1'b0;
         acc_in      = '0;
      end else if (cmd.sum_run) begin
         pend_in = (sum_cnt_ff != '0);
         if (sum_cnt_ff != '0) begin
            sum_cnt_in  = sum_cnt_ff - 1'b1;
            sum_addr_in = (sum_addr_ff == '0) ? WIN_AW'(MAX_WINDOW - 1)
                                              : sum_addr_ff - 1'b1;
         end
         if (pend_ff) begin
            acc_in = acc_ff + SUM_W'(close_rd);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_cnt_ff <= '0;
         pend_ff    <= 1'b0;
      end else begin
         sum_cnt_ff <= sum_cnt_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_addr_ff <= sum_addr_in;
      acc_ff      <= acc_in;
   end

   marc_ram #(
      .WIDTH (PRICE_W),
      .DEPTH (MAX_WINDOW)
   ) u_close_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (cslot),
      .wr_data (close_ff),
      .rd_addr (sum_addr_ff),
      .rd_data (close_rd)
   );

   marc_ram #(
      .WIDTH (PRICE_W),
      .DEPTH (OPEN_DEPTH)
   ) u_open_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (oslot),
      .wr_data (open_ff),
      .rd_addr (ref_addr_ff),
      .rd_data (open_rd)
   );

   // ---- reference open, latched when the mean division starts ----
   always_ff @(posedge clock) begin
      if (cmd.div_ma_start) begin
         ref_ff <= open_rd;
         neg_ff <= (close_ff < open_rd);
         mag_ff <= (close_ff < open_rd) ? open_rd - close_ff : close_ff - open_rd;
      end
   end

   // ---- shared divider ----
   assign div_start    = cmd.div_ma_start || cmd.div_rate_start;
   assign div_dividend = cmd.div_rate_start ? {mag_ff, FRAC_BITS'(0)} : DIVD_W'(acc_ff);
   assign div_divisor  = cmd.div_rate_start ? ref_ff : DIVS_W'(n_ff);

   marc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // Saturate the magnitude, then negate in the rate width when falling.
   always_comb begin
      if (neg_ff) begin
         rate_mag = (div_quotient > RATE_NEG_MAG) ? RATE_NEG_MAG : div_quotient;
         rate_sat = ~rate_mag[RATE_W-1:0] + 1'b1;
      end else begin
         rate_mag = (div_quotient > RATE_POS_MAX) ? RATE_POS_MAX : div_quotient;
         rate_sat = rate_mag[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ma_take) begin
         mean_ff       <= div_quotient[PRICE_W-1:0];
         rate_ff       <= '0;
         rate_valid_ff <= (ref_ff != '0);
      end else if (cmd.rate_take) begin
         rate_ff <= rate_sat;
      end
   end

   // ---- result register ----
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_mean_ff       <= mean_ff;
         out_rate_ff       <= rate_ff;
         out_rate_valid_ff <= rate_valid_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_moving_average = out_mean_ff;
   assign rsp_change_rate    = out_rate_ff;
   assign rsp_rate_valid     = out_rate_valid_ff;

   assign status.sum_done = (sum_cnt_ff == '0) && !pend_ff;
   assign status.div_done = div_done;
   assign status.ref_zero = (ref_ff == '0);
   assign status.out_free = !out_valid_ff || rsp_ready;

endmodule

/* src/marc_ctrl.sv */
// ----------------------------------------------------------------------------
// Moving average and rate of change: controller
// Sequences one bar through store, accumulation, one or two divisions and output.
// ----------------------------------------------------------------------------
module marc_ctrl import marc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_STORE    = 6'b000010,
      ST_SUM      = 6'b000100,
      ST_DIV_MA   = 6'b001000,
      ST_DIV_RATE = 6'b010000,
      ST_FINISH   = 6'b100000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_run = 1'b1;
            if (status.sum_done) begin
               cmd.div_ma_start = 1'b1;
               state_in         = ST_DIV_MA;
            end
         end
         ST_DIV_MA: begin
            if (status.div_done) begin
               cmd.ma_take = 1'b1;
               if (status.ref_zero) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.div_rate_start = 1'b1;
                  state_in           = ST_DIV_RATE;
               end
            end
         end
         ST_DIV_RATE: begin
            if (status.div_done) begin
               cmd.rate_take = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted bar always moves on to the store step.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_STORE))
      else $error("accepted bar did not reach the store step");

   // A result is only loaded when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result loaded over an untaken result");

   // The rate division is never run against a zero reference open.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RATE) |-> !status.ref_zero)
      else $error("rate division with zero reference");

endmodule

/* src/moving_average_rate_of_change_top.sv */
// ----------------------------------------------------------------------------
// Moving average and rate of change: top level
// Takes one price bar per transfer and returns its moving average of closes
// and its signed Q8.16 rate of change against the open of the same or an earlier bar.
// ----------------------------------------------------------------------------
// Usage. Each bar arrives as one transfer on the req_ channel: open and close
// in tdata, the series start flag in tuser. Every bar gives exactly one
// transfer on the rsp_ channel: the truncated mean of the last min(bars in
// series, ma_window clamped to 1..64) closes, the rate of change and its
// valid flag. The user must write the two registers through the csr_ channel
// only while the block is idle; the block does not enforce this. csr_ready
// is always high.
// Operation. A bar is stored, then the n closes averaged (at most 64) are read
// one per cycle from the close history memory, then the mean and the rate go
// one after the other through a single restoring divider that produces one
// quotient bit per cycle. With a zero reference open the rate division is
// skipped. One bar is processed at a time; req_tready is high only between
// bars.
// Reset (synchronous, active high) restores the default registers and empties
// the series, so the first bar begins a new series. If the receiver stalls,
// the result waits in the output register; the next bar may be taken and
// processed meanwhile, and it waits only to hand over its own result.
// ----------------------------------------------------------------------------
module moving_average_rate_of_change_top import marc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // req_tdata: open_price [31:0], close_price [63:32]
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,
   // req_tuser: series_start [0]
   input  logic                 req_tuser,
   // rsp_tdata: moving_average [31:0], change_rate [55:32]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [55:0]          rsp_tdata,
   // rsp_tuser: rate_valid [0]
   output logic                 rsp_tuser,
   // Configuration: index 0 is ma_window, index 1 is rate_lag.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [PRICE_W-1:0] moving_average;
   logic [RATE_W-1:0]  change_rate;
   logic               rate_valid;

   // Register writes are always taken in the cycle they are offered.
   assign csr_ready = 1'b1;

   marc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   marc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_series_start   (req_tuser),
      .req_open_price     (req_tdata[31:0]),
      .req_close_price    (req_tdata[63:32]),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_ready          (rsp_tready),
      .rsp_valid          (rsp_tvalid),
      .rsp_moving_average (moving_average),
      .rsp_change_rate    (change_rate),
      .rsp_rate_valid     (rate_valid)
   );

   // The fields pack without gaps into seven bytes.
   assign rsp_tdata = {change_rate, moving_average};
   assign rsp_tuser = rate_valid;

endmodule

/* sim/marc_result_checker.sv */
// ----------------------------------------------------------------------------
// Moving average and rate of change: result checker
// Watches the bar, result and register channels, keeps its own copy of the
// price history and registers, predicts the result of every accepted bar and
// compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module marc_result_checker import marc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [63:0]          req_tdata,
   input  logic                 req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [55:0]          rsp_tdata,
   input  logic                 rsp_tuser,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   output int                   fail_count,
   output int                   pending,
   output int                   results_checked
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [PRICE_W-1:0] mean;
      logic [RATE_W-1:0]  rate;
      logic               rate_ok;
   } bar_result_type;

   logic [PRICE_W-1:0] close_mem [MAX_WINDOW];
   logic [PRICE_W-1:0] open_mem  [OPEN_DEPTH];
   int unsigned        bars_in_series;
   int unsigned        open_slot;
   int unsigned        close_slot;
   logic [CFG_W-1:0]   window_reg;
   logic [CFG_W-1:0]   lag_reg;

   bar_result_type     expected_q [$];
   bar_result_type     want;

   initial begin
      fail_count      = 0;
      pending         = 0;
      results_checked = 0;
   end

   function automatic void clear_history();
      foreach (close_mem[i]) close_mem[i] = '0;
      foreach (open_mem[i]) open_mem[i] = '0;
      bars_in_series = 0;
      open_slot      = 0;
      close_slot     = 0;
   endfunction

   // Works out the result of one bar and advances the history.
   function automatic bar_result_type predict_bar(input logic start,
                                                  input logic [PRICE_W-1:0] open_p,
                                                  input logic [PRICE_W-1:0] close_p);
      int unsigned        win;
      int unsigned        lag;
      int unsigned        n;
      int unsigned        back;
      int unsigned        k;
      longint unsigned    sum;
      longint unsigned    mag;
      logic               neg;
      logic [PRICE_W-1:0] ref_open;
      bar_result_type     r;

      if (start)
         clear_history();

      win = window_reg;
      if (win == 0)
         win = 1;
      if (win > MAX_WINDOW)
         win = MAX_WINDOW;
      lag = lag_reg;
      if (lag > MAX_LAG)
         lag = MAX_LAG;

      close_mem[close_slot] = close_p;
      open_mem[open_slot]   = open_p;
      if (bars_in_series < SEEN_CAP)
         bars_in_series++;

      // Short series are averaged over the bars seen so far.
      n   = (bars_in_series < win) ? bars_in_series : win;
      sum = 0;
      for (k = 0; k < n; k++)
         sum += close_mem[(close_slot + MAX_WINDOW - k) % MAX_WINDOW];
      r.mean = PRICE_W'(sum / n);

      // A lag reaching before the series start falls back to its first bar.
      back     = (lag < bars_in_series - 1) ? lag : bars_in_series - 1;
      ref_open = open_mem[(open_slot + OPEN_DEPTH - back) % OPEN_DEPTH];
      if (ref_open == 0) begin
         r.rate    = '0;
         r.rate_ok = 1'b0;
      end else begin
         neg = close_p < ref_open;
         mag = neg ? longint'(ref_open - close_p) : longint'(close_p - ref_open);
         mag = (mag << FRAC_BITS) / longint'(ref_open);
         if (neg && mag > 64'd8388608)
            mag = 64'd8388608;
         if (!neg && mag > 64'd8388607)
            mag = 64'd8388607;
         r.rate    = neg ? RATE_W'(64'd0 - mag) : RATE_W'(mag);
         r.rate_ok = 1'b1;
      end

      close_slot = (close_slot + 1) % MAX_WINDOW;
      open_slot  = (open_slot + 1) % OPEN_DEPTH;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned exp_v);
      if (fail_count < PRINT_CAP)
         $display("%t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                  exp_v);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_history();
         window_reg = WINDOW_RESET;
         lag_reg    = LAG_RESET;
         expected_q.delete();
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MA_WINDOW: window_reg = csr_data;
               CSR_RATE_LAG:  lag_reg    = csr_data;
               default: ;
            endcase
         end
         // Results are matched before the new bar is queued, so a result can
         // never be paired with the bar accepted at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result with no bar outstanding", rsp_tdata, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[31:0] !== want.mean)
                  report_mismatch("moving_average", rsp_tdata[31:0], want.mean);
               if (rsp_tdata[55:32] !== want.rate)
                  report_mismatch("change_rate", rsp_tdata[55:32], want.rate);
               if (rsp_tuser !== want.rate_ok)
                  report_mismatch("rate_valid", rsp_tuser, want.rate_ok);
               results_checked++;
            end
         end
         if (req_tvalid && req_tready)
            expected_q.insert(expected_q.size(),
                              predict_bar(req_tuser, req_tdata[31:0], req_tdata[63:32]));
         pending <= expected_q.size();
      end
   end

endmodule

/* sim/moving_average_rate_of_change_top_test.sv */
// ----------------------------------------------------------------------------
// Moving average and rate of change: testbench top
// Drives price bars and register writes into the block, with random bursts on
// the bar channel and random stalls on the result channel, and gives the
// verdict from the failure count of the result checker.
// ----------------------------------------------------------------------------
module moving_average_rate_of_change_top_test import marc_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // The limit is several times the longest quiet stretch of a correct run,
   // which covers a bar's processing, a stalled receiver and a sender gap.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 250;
   localparam int RANDOM_BARS    = 650;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [63:0]          req_tdata  = '0;    // open_price [31:0], close_price [63:32]
   logic                 req_tuser  = 1'b0;  // series_start [0]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [55:0]          rsp_tdata;          // moving_average [31:0], change_rate [55:32]
   logic                 rsp_tuser;          // rate_valid [0]
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = CSR_MA_WINDOW;
   logic [CFG_W-1:0]     csr_data   = '0;

   int                   fail_count;
   int                   pending;
   int                   results_checked;

   // Sender burst control, owned by the stimulus process alone.
   int unsigned          burst_left = 0;
   int unsigned          gap_max    = 0;
   int unsigned          bars_sent  = 0;
   int unsigned          series_count = 0;
   int unsigned          settings_count = 1;

   // Receiver stall pattern.
   logic                 stall_enable = 1'b0;
   int unsigned          hold_left    = 0;
   int unsigned          quiet_cycles = 0;

   moving_average_rate_of_change_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   marc_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver holds its ready level for a random number of cycles, mostly
   // ready, sometimes stalling long enough to overlap the next bar's
   // processing. With stalling switched off it takes every result at once.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!stall_enable) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 2) != 0);
         hold_left  <= $urandom_range(0, ($urandom_range(0, 1) != 0) ? 3 : 120);
      end
   end

   // The watchdog ends the run if no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one bar and returns once it has been accepted. A new burst may
   // open with a gap, during which tvalid is low.
   task automatic send_bar(input logic start, input logic [31:0] open_p,
                           input logic [31:0] close_p);
      if (burst_left == 0) begin
         if (gap_max != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {close_p, open_p};
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      bars_sent++;
      if (start)
         series_count++;
   endtask

   // Stops offering bars and waits until every result has been handed over.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Writes both registers back to back; csr_valid stays high between the two
   // transfers.
   task automatic write_config(input logic [CFG_W-1:0] window, input logic [CFG_W-1:0] lag);
      csr_valid <= 1'b1;
      csr_index <= CSR_MA_WINDOW;
      csr_data  <= window;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_RATE_LAG;
      csr_data  <= lag;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // Next price of a random walk: mostly a move of up to an eighth of the
   // previous price, now and then zero, full scale or anything at all.
   function automatic logic [31:0] drift_price(input logic [31:0] prev);
      longint step_max;
      longint v;

      case ($urandom_range(0, 24))
         0: return '0;
         1: return '1;
         2: return $urandom;
         default: begin
            step_max = longint'(prev >> 3) + 2;
            v = longint'(prev) + longint'($urandom_range(0, 32'(2 * step_max))) - step_max;
            if (v < 0)
               v = 0;
            if (v > 64'hFFFF_FFFF)
               v = 64'hFFFF_FFFF;
            return v[31:0];
         end
      endcase
   endfunction

   initial begin
      int unsigned phase;
      int unsigned phase_target;
      int unsigned phase_bars;
      int unsigned random_bars;
      int unsigned len;
      logic [6:0]  new_window;
      logic [6:0]  new_lag;
      logic [31:0] open_p;
      logic [31:0] close_p;
      logic        long_done;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed bars under the reset settings, a window of 5 and a lag of 40.
      // The first bar carries no start flag and must still open a series.
      send_bar(1'b0, 32'd10000, 32'd10500);
      send_bar(1'b0, 32'd10500, 32'd9800);
      send_bar(1'b0, 32'd9800, 32'd9800);
      // A zero reference open clears the valid flag, also for later bars
      // whose lag falls back to that first bar.
      send_bar(1'b1, 32'd0, 32'd12345);
      send_bar(1'b0, 32'd5000, 32'd6000);
      // Full-scale rise against an open of 1 saturates the rate.
      send_bar(1'b1, 32'd1, 32'hFFFF_FFFF);
      // Full-scale closes exercise the largest window sum under this window.
      repeat (4) send_bar(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_bar(1'b0, 32'hFFFF_FFFF, 32'd0);
      // A fall to zero is exactly minus one; a tiny fall truncates to zero.
      send_bar(1'b1, 32'hFFFF_FFFF, 32'd0);
      send_bar(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_bar(1'b0, 32'd2, 32'd3);
      wait_idle();

      // Window of one and no lag: each bar is measured against its own open.
      write_config(7'd1, 7'd0);
      send_bar(1'b1, 32'd100, 32'd250);
      send_bar(1'b0, 32'd3, 32'd0);
      send_bar(1'b0, 32'd0, 32'd7);
      send_bar(1'b0, 32'd65536, 32'd65537);
      wait_idle();

      // Random phases. The first few use the register extremes, including a
      // zero window and windows above the history depth; the rest are random.
      random_bars = 0;
      phase       = 0;
      while (random_bars < RANDOM_BARS) begin
         case (phase)
            0: begin new_window = 7'd1;   new_lag = 7'd0;   end
            1: begin new_window = 7'd64;  new_lag = 7'd127; end
            2: begin new_window = 7'd0;   new_lag = 7'd1;   end
            3: begin new_window = 7'd127; new_lag = 7'd127; end
            4: begin new_window = 7'd65;  new_lag = 7'd64;  end
            default: begin
               new_window = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                        : 7'($urandom_range(1, 64));
               new_lag    = 7'($urandom_range(0, 127));
            end
         endcase
         write_config(new_window, new_lag);

         // Idling for this phase: none, short gaps, or gaps long enough to
         // land on any stage of a bar's processing.
         case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 4;
            default: gap_max = 250;
         endcase
         stall_enable <= (phase % 3 != 0) ? ($urandom_range(0, 3) != 0) : 1'b0;

         // The phase with the widest settings also carries one long series,
         // so that both histories wrap and the bar count saturates.
         phase_target = (phase == 1) ? 170 : 45;
         phase_bars   = 0;
         long_done    = 1'b0;
         while (phase_bars < phase_target) begin
            if ($urandom_range(0, 9) < 8) begin
               // A well-formed series: start flag, then a random walk of bars.
               if (phase == 1 && !long_done) begin
                  len       = 150;
                  long_done = 1'b1;
               end else begin
                  len = $urandom_range(1, 40);
               end
               close_p = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2000000) : $urandom;
               for (int unsigned b = 0; b < len; b++) begin
                  open_p  = drift_price(close_p);
                  close_p = drift_price(open_p);
                  send_bar(b == 0, open_p, close_p);
               end
            end else begin
               // Noise: unrelated prices with a random start flag.
               len = $urandom_range(1, 6);
               for (int unsigned b = 0; b < len; b++)
                  send_bar(1'($urandom_range(0, 1)), $urandom, $urandom);
            end
            phase_bars += len;
         end
         random_bars += phase_bars;
         wait_idle();
         phase++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d bars in %0d started series over %0d register settings,",
               bars_sent, series_count, settings_count);
      $display("with %0d results compared under bursty input and stalled output.",
               results_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
